// ===== rtl/cfc_pkg.sv =====
// Shared types and constants of the chunked frame checker.
package cfc_pkg;

    // Field widths fixed by the datagram format.
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 11;
    localparam int LEN_W   = 11;
    localparam int HDR16_W = 16;
    localparam int TOTAL_W = 17;

    // Framing bytes and header layout.
    localparam logic [BYTE_W-1:0] STX_BYTE     = 8'h54;
    localparam logic [BYTE_W-1:0] ETX_BYTE     = 8'h45;
    localparam logic [POS_W-1:0]  POS_STX      = 11'd0;
    localparam logic [POS_W-1:0]  POS_LEN_A    = 11'd1;
    localparam logic [POS_W-1:0]  POS_LEN_B    = 11'd2;
    localparam logic [POS_W-1:0]  POS_FLAG     = 11'd3;
    localparam logic [POS_W-1:0]  POS_WAIT_A   = 11'd4;
    localparam logic [POS_W-1:0]  POS_WAIT_B   = 11'd5;
    localparam logic [POS_W-1:0]  HEADER_BYTES = 11'd6;
    localparam logic [POS_W-1:0]  POS_MAX      = 11'd2047;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict codes.
    localparam logic [1:0] VERDICT_ERROR    = 2'd0;
    localparam logic [1:0] VERDICT_MORE     = 2'd1;
    localparam logic [1:0] VERDICT_COMPLETE = 2'd2;

    // One result item.
    typedef struct packed {
        logic               out_kind;
        logic [BYTE_W-1:0]  payload_byte;
        logic [1:0]         verdict;
        logic [LEN_W-1:0]   chunk_length;
        logic [TOTAL_W-1:0] total_length;
        logic               send_ack;
        logic               ack_state;
    } cfc_result_t;

endpackage

// ===== rtl/chunked_frame_checker.sv =====
// Top level of the chunked frame checker: byte-stream datagram checker.
//
//  Channel  Direction  Ports                                   Meaning
//  cfg      in         cfg_valid/ready, cfg_length_msb_first   header byte order
//  s        in         s_valid/ready, s_rx_byte, s_end_of_...  one datagram byte
//  m        out        m_valid/ready, m_out_kind ... m_ack_... payload or verdict
//
// Each byte is checked combinationally; its result, if any, is registered into
// the output or skid stage; a new byte is taken every cycle that s_ready is high.
// The output register plus a one-item skid stage decouple the two sides:
// s_ready falls only when both are full under an m_ stall.
// Reset is synchronous and active low; it clears all state but the buffered
// result data and sets high-byte-first order. cfg_ready is always high.
module chunked_frame_checker #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int MAX_TOTAL   = 65536
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_length_msb_first,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cfc_pkg::BYTE_W-1:0]   s_rx_byte,
    input  logic                         s_end_of_datagram,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic                         m_out_kind,
    output logic [cfc_pkg::BYTE_W-1:0]   m_payload_byte,
    output logic [1:0]                   m_verdict,
    output logic [cfc_pkg::LEN_W-1:0]    m_chunk_length,
    output logic [cfc_pkg::TOTAL_W-1:0]  m_total_length,
    output logic                         m_send_ack,
    output logic                         m_ack_state
);
    import cfc_pkg::*;

    logic        length_msb_first_reg;
    logic        in_accept;
    logic        res_valid;
    cfc_result_t res_data;
    cfc_result_t out_data;

    assign cfg_ready = 1'b1;
    assign in_accept = s_valid && s_ready;

    // Byte order register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            length_msb_first_reg <= 1'b1;
        end else if (cfg_valid) begin
            length_msb_first_reg <= cfg_length_msb_first;
        end
    end

    cfc_parser #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .MAX_TOTAL   (MAX_TOTAL)
    ) u_parser (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_accept        (in_accept),
        .rx_byte          (s_rx_byte),
        .end_of_datagram  (s_end_of_datagram),
        .length_msb_first (length_msb_first_reg),
        .res_valid        (res_valid),
        .res_data         (res_data)
    );

    cfc_out_buf u_out_buf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (in_accept && res_valid),
        .push_data  (res_data),
        .push_ready (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_data)
    );

    // Result item onto its ports.
    assign m_out_kind     = out_data.out_kind;
    assign m_payload_byte = out_data.payload_byte;
    assign m_verdict      = out_data.verdict;
    assign m_chunk_length = out_data.chunk_length;
    assign m_total_length = out_data.total_length;
    assign m_send_ack     = out_data.send_ack;
    assign m_ack_state    = out_data.ack_state;

endmodule

// ===== rtl/cfc_parser.sv =====
// Datagram parser: per-datagram state, running total and result formation.
module cfc_parser #(
    parameter int MAX_PAYLOAD = 1024,
    parameter int MAX_TOTAL   = 65536
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_accept,
    input  logic [cfc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic                         end_of_datagram,
    input  logic                         length_msb_first,
    output logic                         res_valid,
    output cfc_pkg::cfc_result_t         res_data
);
    import cfc_pkg::*;

    logic [POS_W-1:0]   byte_position_reg, byte_position_next;
    logic [BYTE_W-1:0]  held_header_byte_reg, held_header_byte_next;
    logic [LEN_W-1:0]   frame_length_reg, frame_length_next;
    logic               continue_flag_reg, continue_flag_next;
    logic               frame_bad_reg, frame_bad_next;
    logic [TOTAL_W-1:0] running_total_reg, running_total_next;

    logic [HDR16_W-1:0] length_word;
    logic [POS_W-1:0]   etx_pos;
    logic               is_payload;
    logic               frame_ok;
    logic [TOTAL_W:0]   total_sum;
    logic [TOTAL_W-1:0] total_sat;

    // Length as assembled from the held byte and the current byte.
    assign length_word = length_msb_first ? {held_header_byte_reg, rx_byte}
                                          : {rx_byte, held_header_byte_reg};
    assign etx_pos     = HEADER_BYTES + frame_length_reg;

    // Header checks and payload/ETX classification of the current byte.
    always_comb begin
        held_header_byte_next = held_header_byte_reg;
        frame_length_next     = frame_length_reg;
        continue_flag_next    = continue_flag_reg;
        frame_bad_next        = frame_bad_reg;
        is_payload            = 1'b0;
        if (byte_position_reg == POS_STX) begin
            if (rx_byte != STX_BYTE) begin
                frame_bad_next = 1'b1;
            end
        end else if (byte_position_reg == POS_LEN_A) begin
            held_header_byte_next = rx_byte;
        end else if (byte_position_reg == POS_LEN_B) begin
            // Only the low bits are kept: a longer length marks the frame bad.
            frame_length_next = length_word[LEN_W-1:0];
            if (length_word > HDR16_W'(MAX_PAYLOAD)) begin
                frame_bad_next = 1'b1;
            end
        end else if (byte_position_reg == POS_FLAG) begin
            if (rx_byte > 8'd1) begin
                frame_bad_next = 1'b1;
            end else begin
                continue_flag_next = rx_byte[0];
            end
        end else if (byte_position_reg == POS_WAIT_A ||
                     byte_position_reg == POS_WAIT_B) begin
            if (rx_byte != '0) begin
                frame_bad_next = 1'b1;
            end
        end else if (!frame_bad_reg) begin
            if (byte_position_reg < etx_pos) begin
                is_payload = 1'b1;
            end else if (byte_position_reg == etx_pos && rx_byte != ETX_BYTE) begin
                frame_bad_next = 1'b1;
            end
        end
    end

    // Verdict arithmetic: saturating running total.
    assign frame_ok  = !frame_bad_next && (byte_position_reg >= HEADER_BYTES) &&
                       (byte_position_reg >= etx_pos);
    assign total_sum = {1'b0, running_total_reg} +
                       {{(TOTAL_W + 1 - LEN_W){1'b0}}, frame_length_reg};
    assign total_sat = (total_sum > (TOTAL_W + 1)'(MAX_TOTAL)) ? TOTAL_W'(MAX_TOTAL)
                                                              : total_sum[TOTAL_W-1:0];

    // Result item and next running total.
    always_comb begin
        res_data           = '0;
        res_valid          = 1'b0;
        running_total_next = running_total_reg;
        byte_position_next = (byte_position_reg != POS_MAX) ? byte_position_reg + 11'd1
                                                            : byte_position_reg;
        if (end_of_datagram) begin
            res_valid         = 1'b1;
            res_data.out_kind = KIND_VERDICT;
            if (frame_ok) begin
                res_data.chunk_length = frame_length_reg;
                res_data.total_length = total_sat;
                if (continue_flag_reg) begin
                    res_data.verdict   = VERDICT_MORE;
                    res_data.send_ack  = 1'b1;
                    res_data.ack_state = 1'b1;
                    running_total_next = total_sat;
                end else begin
                    res_data.verdict   = VERDICT_COMPLETE;
                    running_total_next = '0;
                end
            end else begin
                res_data.verdict      = VERDICT_ERROR;
                res_data.send_ack     = 1'b1;
                res_data.total_length = running_total_reg;
            end
        end else if (is_payload) begin
            res_valid             = 1'b1;
            res_data.out_kind     = KIND_PAYLOAD;
            res_data.payload_byte = rx_byte;
        end
    end

    // State registers, updated on each accepted item; a verdict clears the frame.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg    <= '0;
            held_header_byte_reg <= '0;
            frame_length_reg     <= '0;
            continue_flag_reg    <= 1'b0;
            frame_bad_reg        <= 1'b0;
            running_total_reg    <= '0;
        end else if (in_accept) begin
            running_total_reg <= running_total_next;
            if (end_of_datagram) begin
                byte_position_reg    <= '0;
                held_header_byte_reg <= '0;
                frame_length_reg     <= '0;
                continue_flag_reg    <= 1'b0;
                frame_bad_reg        <= 1'b0;
            end else begin
                byte_position_reg    <= byte_position_next;
                held_header_byte_reg <= held_header_byte_next;
                frame_length_reg     <= frame_length_next;
                continue_flag_reg    <= continue_flag_next;
                frame_bad_reg        <= frame_bad_next;
            end
        end
    end

    // A payload item can only come from past the header.
    a_payload_after_header: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid && res_data.out_kind == KIND_PAYLOAD) |->
            (byte_position_reg >= HEADER_BYTES && !frame_bad_reg))
        else $error("payload item inside header or bad frame");

    // A verdict leaves the frame state cleared.
    a_verdict_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && end_of_datagram) |=> (byte_position_reg == '0 && !frame_bad_reg))
        else $error("frame state not cleared after verdict");

    // The running total never passes its ceiling.
    a_total_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, running_total_reg} <= (TOTAL_W + 1)'(MAX_TOTAL))
        else $error("running total above ceiling");

endmodule

// ===== rtl/cfc_out_buf.sv =====
// Result register with a skid stage so input and output stall independently.
module cfc_out_buf (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cfc_pkg::cfc_result_t  push_data,
    output logic                  push_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output cfc_pkg::cfc_result_t  out_data
);
    import cfc_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    cfc_result_t out_data_reg;
    cfc_result_t skid_data_reg;
    logic        pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (push) begin
            if (out_valid_reg && !pop) begin
                skid_data_reg <= push_data;
            end else begin
                out_data_reg <= push_data;
            end
        end
    end

    // The skid stage only holds an item behind a waiting output item.
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid item without output item");

    // Nothing is pushed while the skid stage is full.
    a_no_push_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !skid_valid_reg)
        else $error("item pushed into full buffer");

    // A push against a stalled output lands in the skid stage.
    a_push_to_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && out_valid_reg && !out_ready) |=> skid_valid_reg)
        else $error("item lost on stalled output");

endmodule
